### rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Register indexes, reset values and the control and status bundles that pass
// between the sequencer and the bit-serial modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// Width of the register index on the configuration port.
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd1;

	// Reset values of the registers, cut to the field widths where they are used.
	localparam logic [31:0] EXPONENT_RESET = 32'd1;
	localparam logic [31:0] MODULUS_RESET  = 32'd65535;

	// Request from the sequencer to the multiplier.
	typedef struct packed {
		logic start;
	} mul_ctl_t;

	// Status from the multiplier back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

endpackage

### rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes x * y mod m by interleaved doubling and adding, most significant
// bit of x first, with a doubling step and then an adding step for each bit.
// ----------------------------------------------------------------------------
module mexp_mulmod
	import mexp_pkg::*;
#(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  mul_ctl_t     ctl,
	output mul_sts_t     sts,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic [W-1:0] m,
	output logic [W-1:0] product
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [W-1:0]  m_q;
	logic [W-1:0]  r_q;
	logic [CW-1:0] cnt_q;
	logic          add_phase_q;
	logic          busy_q;
	logic          done_q;

	logic [W-1:0]  addend;
	logic [W:0]    sum;
	logic          sub_ok;
	logic [W:0]    sum_red;

	// One shared adder: r + r on the doubling cycle, r + (bit ? y : 0) on the
	// adding cycle. A zero modulus leaves the sum to wrap at the field width.
	always_comb begin
		if (!add_phase_q) begin
			addend = r_q;
		end else if (x_q[W-1]) begin
			addend = y_q;
		end else begin
			addend = '0;
		end
		sum     = {1'b0, r_q} + {1'b0, addend};
		sub_ok  = (m_q != '0) && (sum >= {1'b0, m_q});
		sum_red = sub_ok ? (sum - {1'b0, m_q}) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			add_phase_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q      <= 1'b1;
				add_phase_q <= 1'b0;
				cnt_q       <= CW'(W - 1);
			end else if (busy_q) begin
				add_phase_q <= !add_phase_q;
				if (add_phase_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x;
			y_q <= y;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= sum_red[W-1:0];
			if (add_phase_q) begin
				x_q <= x_q << 1;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = r_q;

endmodule

### rtl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Raises each base beat to the configured exponent, reduced by the configured
// modulus, using left-to-right square-and-multiply over a bit-serial multiplier.
// ----------------------------------------------------------------------------
// The unit works on one base at a time. Every modular multiplication runs in
// the shared bit-serial multiplier, which takes one bit of the left operand at
// a time in a doubling step and then an adding step. After a base beat is
// accepted, the exponent is shifted left one bit per cycle, by up to EXP_WIDTH-1
// bits, until its top set bit is found, the base is reduced once by the modulus
// (one multiplication by one), and then every exponent bit from the top set bit
// down costs one squaring, plus one multiplication by the base where the bit is
// set. A zero exponent returns 1, unreduced even for a modulus of one. A zero
// modulus makes all arithmetic wrap at VALUE_WIDTH bits. The result sits in an
// output register, so a new base beat is taken while an earlier result waits on
// power_stall. The exponent and modulus registers are written through the cfg
// port, which is always ready; they must only be changed while no base beat is
// in flight.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
	import mexp_pkg::*;
#(
	parameter int VALUE_WIDTH = 16,
	parameter int EXP_WIDTH   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [((VALUE_WIDTH > EXP_WIDTH) ? VALUE_WIDTH : EXP_WIDTH)-1:0] cfg_data,
	// Base input channel
	input  logic                   base_valid,
	output logic                   base_stall,
	input  logic [VALUE_WIDTH-1:0] base,
	// Power output channel
	output logic                   power_valid,
	input  logic                   power_stall,
	output logic [VALUE_WIDTH-1:0] power
);

	localparam int BW = $clog2(EXP_WIDTH + 1);

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SEEK = 6'b000010,
		ST_REDB = 6'b000100,
		ST_SQR  = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_DONE = 6'b100000
	} seq_state_t;

	seq_state_t             state_q;
	logic [EXP_WIDTH-1:0]   exponent_q;
	logic [VALUE_WIDTH-1:0] modulus_q;
	logic [EXP_WIDTH-1:0]   exp_sh_q;
	logic [BW-1:0]          bits_q;
	logic [VALUE_WIDTH-1:0] base_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] power_q;
	logic                   power_valid_q;
	logic                   go_q;

	logic                   base_accept;
	logic                   out_free;
	logic [VALUE_WIDTH-1:0] one_red;
	logic [VALUE_WIDTH-1:0] mul_x;
	logic [VALUE_WIDTH-1:0] mul_y;
	logic [VALUE_WIDTH-1:0] mul_p;
	mul_ctl_t               mul_ctl;
	mul_sts_t               mul_sts;

	// Configuration registers. Writes to indexes beyond the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= EXP_WIDTH'(EXPONENT_RESET);
			modulus_q  <= VALUE_WIDTH'(MODULUS_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data[EXP_WIDTH-1:0];
				REG_MODULUS:  modulus_q  <= cfg_data[VALUE_WIDTH-1:0];
				default:      ;
			endcase
		end
	end

	// One reduced by the modulus: zero for a modulus of one, otherwise one.
	assign one_red = (modulus_q == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);

	assign base_stall  = (state_q != ST_IDLE);
	assign base_accept = base_valid && !base_stall;
	assign out_free    = !power_valid_q || !power_stall;

	// Operand selection for the multiplier; the operands are captured on the
	// start cycle, which follows the state change that selects them.
	always_comb begin
		case (state_q)
			ST_REDB: begin
				mul_x = base_q;
				mul_y = one_red;
			end
			ST_MUL: begin
				mul_x = acc_q;
				mul_y = base_q;
			end
			default: begin
				mul_x = acc_q;
				mul_y = acc_q;
			end
		endcase
	end

	assign mul_ctl.start = go_q;

	mexp_mulmod #(
		.W (VALUE_WIDTH)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.sts     (mul_sts),
		.x       (mul_x),
		.y       (mul_y),
		.m       (modulus_q),
		.product (mul_p)
	);

	// Control part of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			go_q          <= 1'b0;
			power_valid_q <= 1'b0;
			bits_q        <= '0;
		end else begin
			go_q <= 1'b0;
			// A taken result beat empties the output register, unless the
			// finishing item refills it at the same edge.
			if (power_valid_q && !power_stall && state_q != ST_DONE) begin
				power_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (base_accept) begin
						bits_q  <= BW'(EXP_WIDTH);
						state_q <= (exponent_q == '0) ? ST_DONE : ST_SEEK;
					end
				end
				ST_SEEK: begin
					if (exp_sh_q[EXP_WIDTH-1]) begin
						state_q <= ST_REDB;
						go_q    <= 1'b1;
					end else begin
						bits_q <= bits_q - 1'b1;
					end
				end
				ST_REDB: begin
					if (mul_sts.done) begin
						state_q <= ST_SQR;
						go_q    <= 1'b1;
					end
				end
				ST_SQR, ST_MUL: begin
					if (mul_sts.done) begin
						if (state_q == ST_SQR && exp_sh_q[EXP_WIDTH-1]) begin
							state_q <= ST_MUL;
							go_q    <= 1'b1;
						end else if (bits_q == BW'(1)) begin
							state_q <= ST_DONE;
						end else begin
							bits_q  <= bits_q - 1'b1;
							state_q <= ST_SQR;
							go_q    <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						power_valid_q <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Data part of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (base_accept) begin
					base_q   <= base;
					exp_sh_q <= exponent_q;
					acc_q    <= VALUE_WIDTH'(1);
				end
			end
			ST_SEEK: begin
				if (!exp_sh_q[EXP_WIDTH-1]) begin
					exp_sh_q <= exp_sh_q << 1;
				end
			end
			ST_REDB: begin
				if (mul_sts.done) begin
					base_q <= mul_p;
					acc_q  <= one_red;
				end
			end
			ST_SQR, ST_MUL: begin
				if (mul_sts.done) begin
					acc_q <= mul_p;
					if (!(state_q == ST_SQR && exp_sh_q[EXP_WIDTH-1])) begin
						exp_sh_q <= exp_sh_q << 1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					power_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign power_valid = power_valid_q;
	assign power       = power_q;

endmodule

### rtl/mexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the ports of the unit and flags beats that break its sequencing.
// ----------------------------------------------------------------------------
module mexp_checker #(
	parameter int VALUE_WIDTH = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   base_valid,
	input logic                   base_stall,
	input logic                   power_valid,
	input logic                   power_stall,
	input logic [VALUE_WIDTH-1:0] power
);

	// A stalled result beat stays offered with the same value.
	a_power_hold: assert property (@(posedge clk) disable iff (!arst_n)
		power_valid && power_stall |=> power_valid && $stable(power))
		else $error("power beat dropped or changed while stalled");

	// Only one base is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		base_valid && !base_stall |=> base_stall)
		else $error("second base beat taken while one is in flight");

	// A result appears only as the unit returns to idle.
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(power_valid) |-> !base_stall)
		else $error("result raised while still busy");

	// No result can follow an accepted base in the very next cycle.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		base_valid && !base_stall |=> !$rose(power_valid))
		else $error("result appeared too early after a base beat");

endmodule

bind modular_exponentiation_unit mexp_checker #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_mexp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.base_valid  (base_valid),
	.base_stall  (base_stall),
	.power_valid (power_valid),
	.power_stall (power_stall),
	.power       (power)
);

### tb/sv/modular_exponentiation_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation unit testbench
// Drives base beats through the unit under a range of exponent and modulus
// settings. Each result is compared with a locally computed square-and-multiply
// power, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_tb;
	import mexp_pkg::*;

	localparam int VALUE_W = 16;
	localparam int EXP_W   = 16;
	localparam int CFG_W   = (VALUE_W > EXP_W) ? VALUE_W : EXP_W;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	// The run has 579 items, and the cycle limit covers them all at their slowest
	// with room to spare, including idling and the long hold-off.
	localparam int unsigned CYCLE_LIMIT   = 3_000_000;
	localparam int unsigned SETTLE_CYCLES = 1200;
	localparam int unsigned RANDOM_ITEMS  = 546;
	localparam int unsigned HOLD_CYCLES   = 2500;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 base_valid;
	logic                 base_stall;
	logic [VALUE_W-1:0]   base;
	logic                 power_valid;
	logic                 power_stall;
	logic [VALUE_W-1:0]   power;

	// Local copy of the configuration, updated as each register write is taken.
	logic [EXP_W-1:0]     cur_exponent;
	logic [VALUE_W-1:0]   cur_modulus;

	// Powers still owed by the unit, oldest first.
	logic [VALUE_W-1:0]   powers_due[$];

	int unsigned          err_count;
	int unsigned          cycle_count;
	int unsigned          hold_request;
	bit                   idle_on;

	modular_exponentiation_unit #(
		.VALUE_WIDTH(VALUE_W),
		.EXP_WIDTH  (EXP_W)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.base_valid (base_valid),
		.base_stall (base_stall),
		.base       (base),
		.power_valid(power_valid),
		.power_stall(power_stall),
		.power      (power)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Square-and-multiply from the top set exponent bit down. A zero exponent
	// gives 1 without any reduction, and a zero modulus lets the products
	// simply wrap at the value width.
	function automatic logic [VALUE_W-1:0] predict_power(input logic [VALUE_W-1:0] b,
			input logic [EXP_W-1:0] e, input logic [VALUE_W-1:0] m);
		longint unsigned acc;
		int top;
		if (e == '0)
			return 1;
		top = -1;
		for (int k = 0; k < EXP_W; k++) begin
			if (e[k])
				top = k;
		end
		acc = 1;
		for (int k = top; k >= 0; k--) begin
			acc = acc * acc;
			acc = (m == '0) ? (acc & ((64'd1 << VALUE_W) - 1)) : (acc % m);
			if (e[k]) begin
				acc = acc * b;
				acc = (m == '0) ? (acc & ((64'd1 << VALUE_W) - 1)) : (acc % m);
			end
		end
		return acc[VALUE_W-1:0];
	endfunction

	// Mostly uniform bases, with the edges and the values around the modulus
	// mixed in so that bases at or above the modulus turn up often.
	function automatic logic [VALUE_W-1:0] pick_base();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return cur_modulus;
			3: return cur_modulus - 1'b1;
			default: return VALUE_W'($urandom());
		endcase
	endfunction

	// One register write. The valid is left high when another write follows,
	// so that it is never lowered and raised again between the two writes.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (last)
			cfg_valid <= 1'b0;
		case (idx)
			REG_EXPONENT: cur_exponent = value[EXP_W-1:0];
			REG_MODULUS:  cur_modulus  = value[VALUE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [EXP_W-1:0] e, input logic [VALUE_W-1:0] m);
		write_reg(REG_EXPONENT, CFG_W'(e), 1'b0);
		write_reg(REG_MODULUS, CFG_W'(m), 1'b1);
	endtask

	// Offers one base beat after a random gap and holds it until it is taken.
	// With no gap the valid simply stays high from the previous beat.
	task automatic send_base(input logic [VALUE_W-1:0] value);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			base_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		base_valid <= 1'b1;
		base       <= value;
		do @(posedge clk); while (base_stall);
		powers_due.push_back(predict_power(value, cur_exponent, cur_modulus));
	endtask

	// Ends the current run of beats and waits until every power has come back,
	// which leaves the unit idle and safe to reconfigure.
	task automatic drain();
		base_valid <= 1'b0;
		while (powers_due.size() != 0)
			@(posedge clk);
	endtask

	// Reset values: an exponent of one, so each power is the base reduced by
	// the full-range modulus, including a base equal to the modulus.
	task automatic test_reset_values();
		send_base(16'h0000);
		send_base(16'h0001);
		send_base(16'h5555);
		send_base(16'hAAAA);
		send_base(16'hFFFE);
		send_base(16'hFFFF);
		drain();
	endtask

	// A zero exponent gives 1 whatever the base, even for a modulus of one
	// or zero.
	task automatic test_zero_exponent();
		configure(16'h0000, 16'h0001);
		send_base(16'h0000);
		send_base(16'hFFFF);
		send_base(16'h1234);
		drain();
		configure(16'h0000, 16'h0000);
		send_base(16'h0007);
		drain();
	endtask

	// A zero modulus leaves the arithmetic wrapping at the value width.
	task automatic test_zero_modulus();
		configure(16'hFFFF, 16'h0000);
		send_base(16'h0003);
		send_base(16'hFFFF);
		send_base(16'h8001);
		drain();
	endtask

	// Register extremes: the longest exponent, a lone top exponent bit, the
	// smallest non-zero moduli and a power-of-two modulus.
	task automatic test_extreme_registers();
		configure(16'hFFFF, 16'hFFFF);
		send_base(16'hFFFF);
		send_base(16'hFFFE);
		send_base(16'h0002);
		drain();
		configure(16'h8000, 16'h0001);
		send_base(16'h0005);
		drain();
		configure(16'hFFFF, 16'h0002);
		send_base(16'h0003);
		drain();
		configure(16'h0002, 16'h8000);
		send_base(16'h8000);
		drain();
	endtask

	// Writes to the unused indexes must leave both registers as they were.
	task automatic test_spare_indexes();
		write_reg(REG_SPARE_LO, CFG_W'($urandom()), 1'b0);
		write_reg(REG_SPARE_HI, CFG_W'($urandom()), 1'b1);
		send_base(16'h0003);
		send_base(pick_base());
		drain();
	endtask

	// The output side holds off for a long stretch while beats keep coming,
	// so the result register and the datapath fill and the input stalls.
	task automatic test_backpressure();
		configure(16'd3, 16'($urandom_range(3, 65535)));
		hold_request = HOLD_CYCLES;
		repeat (12)
			send_base(pick_base());
		drain();
	endtask

	// Random phases, each with its own exponent and modulus. Short exponents
	// are favoured to keep the run time down, but full-length ones and every
	// register extreme come up regularly. Some phases run with no idling.
	task automatic test_random_phases();
		int unsigned left;
		int unsigned n;
		logic [EXP_W-1:0] e;
		logic [VALUE_W-1:0] m;
		left = RANDOM_ITEMS;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0: e = '0;
				1: e = 16'd1;
				2: e = '1;
				3: e = 16'h8000;
				4, 5, 6: e = 16'($urandom_range(2, 255));
				default: e = 16'($urandom());
			endcase
			case ($urandom_range(0, 9))
				0: m = '0;
				1: m = 16'd1;
				2: m = 16'd2;
				3: m = '1;
				4: m = 16'h8000;
				5: m = 16'($urandom_range(3, 255));
				default: m = 16'($urandom_range(3, 65535));
			endcase
			configure(e, m);
			idle_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(15, 40);
			if (n > left)
				n = left;
			repeat (n)
				send_base(pick_base());
			left -= n;
			drain();
		end
		idle_on = 1'b1;
	endtask

	// Output side: after each taken beat it stalls for a random number of
	// cycles, or for the long hold-off when one has been asked for.
	initial begin : power_sink
		int unsigned pause;
		pause       = 0;
		power_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				pause        = hold_request;
				hold_request = 0;
			end else if (power_valid && !power_stall) begin
				pause = idle_on ? $urandom_range(0, 9) : 0;
			end else if (pause != 0) begin
				pause--;
			end
			power_stall <= (pause != 0);
		end
	end

	// Every taken power beat is matched against the oldest outstanding one.
	always @(posedge clk) begin : power_check
		logic [VALUE_W-1:0] want;
		if (arst_n && power_valid && !power_stall) begin
			if (powers_due.size() == 0) begin
				$error("power: no result expected, got %0d", power);
				err_count++;
			end else begin
				want = powers_due.pop_front();
				if (power !== want) begin
					$error("power: expected %0d, got %0d", want, power);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_EXPONENT;
		cfg_data     = '0;
		base_valid   = 1'b0;
		base         = '0;
		idle_on      = 1'b1;
		hold_request = 0;
		err_count    = 0;
		cycle_count  = 0;
		cur_exponent = EXPONENT_RESET[EXP_W-1:0];
		cur_modulus  = MODULUS_RESET[VALUE_W-1:0];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_zero_exponent();
		test_zero_modulus();
		test_extreme_registers();
		test_spare_indexes();
		test_backpressure();
		test_random_phases();

		// Any stray beat after the last expected power is caught by the power_check block.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
